// ===== hw/rtl/rlol_pkg.sv =====
// ----------------------------------------------------------------------------
// rlol_pkg
// Shared types and constants for the run-length offset lookup block.
// ----------------------------------------------------------------------------
package rlol_pkg;

  localparam int unsigned MaxRuns = 256;
  localparam int unsigned IdxW    = (MaxRuns > 1) ? $clog2(MaxRuns) : 1;
  localparam int unsigned CntW    = $clog2(MaxRuns + 1);
  localparam int unsigned DataW   = 32;
  localparam int unsigned FirstW  = 40;

  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpAppend = 2'd1,
    OpQuery  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StSeek,
    StCmp,
    StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd_en;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic walk_end;
    logic covered;
  } sts_t;

endpackage

// ===== hw/rtl/rlol_in_if.sv =====
// ----------------------------------------------------------------------------
// rlol_in_if
// Request channel: table operation and its operands.
// ----------------------------------------------------------------------------
interface rlol_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] run_length;
  logic [31:0] run_value;
  logic [31:0] lookup_index;

  modport source (output valid, output op, output run_length, output run_value,
                  output lookup_index, input ready);
  modport sink (input valid, input op, input run_length, input run_value,
                input lookup_index, output ready);
endinterface

// ===== hw/rtl/rlol_out_if.sv =====
// ----------------------------------------------------------------------------
// rlol_out_if
// Response channel: lookup value, hit flag and append status.
// ----------------------------------------------------------------------------
interface rlol_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] offset_value;
  logic        hit;
  logic        status;

  modport source (output valid, output offset_value, output hit, output status,
                  input ready);
  modport sink (input valid, input offset_value, input hit, input status,
                output ready);
endinterface

// ===== hw/rtl/rlol_datapath.sv =====
// ----------------------------------------------------------------------------
// rlol_datapath
// Run tables, cursor, walk arithmetic, result and output registers.
// ----------------------------------------------------------------------------
module rlol_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rlol_pkg::cmd_t       cmd_i,
  output rlol_pkg::sts_t       sts_o,
  input  logic [1:0]           op_i,
  input  logic [31:0]          run_length_i,
  input  logic [31:0]          run_value_i,
  input  logic [31:0]          lookup_index_i,
  output logic [31:0]          offset_value_o,
  output logic                 hit_o,
  output logic                 status_o
);

  logic [1:0]                      op_q;
  logic [rlol_pkg::DataW-1:0]      len_q;
  logic [rlol_pkg::DataW-1:0]      val_q;
  logic [rlol_pkg::DataW-1:0]      idx_q;

  logic [rlol_pkg::CntW-1:0]       entries_q;
  logic [rlol_pkg::CntW-1:0]       cur_entry_q;
  logic [rlol_pkg::FirstW-1:0]     cur_first_q;

  logic [rlol_pkg::DataW-1:0]      cnt_rd_q;
  logic [rlol_pkg::DataW-1:0]      val_rd_q;

  logic [rlol_pkg::DataW-1:0]      res_value_q;
  logic                            res_hit_q;
  logic                            res_status_q;
  logic [rlol_pkg::DataW-1:0]      out_value_q;
  logic                            out_hit_q;
  logic                            out_status_q;

  logic [rlol_pkg::DataW-1:0]      cnt_mem [rlol_pkg::MaxRuns];
  logic [rlol_pkg::DataW-1:0]      val_mem [rlol_pkg::MaxRuns];

  logic [rlol_pkg::FirstW-1:0]     idx_ext;
  logic [rlol_pkg::FirstW-1:0]     run_end;
  logic                            covered;
  logic                            before_cursor;
  logic                            walk_end;
  logic                            full;
  logic                            is_append;
  logic                            do_write;

  assign idx_ext       = {{(rlol_pkg::FirstW - rlol_pkg::DataW){1'b0}}, idx_q};
  assign run_end       = cur_first_q + {{(rlol_pkg::FirstW - rlol_pkg::DataW){1'b0}}, cnt_rd_q};
  assign covered       = idx_ext < run_end;
  assign before_cursor = idx_ext < cur_first_q;
  assign walk_end      = cur_entry_q >= entries_q;
  assign full          = entries_q == rlol_pkg::CntW'(rlol_pkg::MaxRuns);
  assign is_append     = rlol_pkg::op_e'(op_q) == rlol_pkg::OpAppend;
  assign do_write      = cmd_i.exec && is_append && !full;

  assign sts_o.is_query = rlol_pkg::op_e'(op_q) == rlol_pkg::OpQuery;
  assign sts_o.walk_end = walk_end;
  assign sts_o.covered  = covered;

  // table fill level and walk cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q   <= '0;
      cur_entry_q <= '0;
      cur_first_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        case (rlol_pkg::op_e'(op_q))
          rlol_pkg::OpClear: begin
            entries_q   <= '0;
            cur_entry_q <= '0;
            cur_first_q <= '0;
          end
          rlol_pkg::OpAppend: begin
            if (!full) begin
              entries_q   <= entries_q + rlol_pkg::CntW'(1);
              cur_entry_q <= '0;
              cur_first_q <= '0;
            end
          end
          rlol_pkg::OpQuery: begin
            if (before_cursor) begin
              cur_entry_q <= '0;
              cur_first_q <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.step && !covered) begin
        cur_first_q <= run_end;
        cur_entry_q <= cur_entry_q + rlol_pkg::CntW'(1);
      end
    end
  end

  // item, result and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      len_q <= run_length_i;
      val_q <= run_value_i;
      idx_q <= lookup_index_i;
    end
    if (cmd_i.exec) begin
      res_value_q  <= '0;
      res_hit_q    <= 1'b0;
      res_status_q <= is_append && full;
    end
    if (cmd_i.step && covered) begin
      res_value_q <= val_rd_q;
      res_hit_q   <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_value_q  <= res_value_q;
      out_hit_q    <= res_hit_q;
      out_status_q <= res_status_q;
    end
  end

  // run tables
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      cnt_mem[entries_q[rlol_pkg::IdxW-1:0]] <= len_q;
      val_mem[entries_q[rlol_pkg::IdxW-1:0]] <= val_q;
    end
    if (cmd_i.rd_en) begin
      cnt_rd_q <= cnt_mem[cur_entry_q[rlol_pkg::IdxW-1:0]];
      val_rd_q <= val_mem[cur_entry_q[rlol_pkg::IdxW-1:0]];
    end
  end

  assign offset_value_o = out_value_q;
  assign hit_o          = out_hit_q;
  assign status_o       = out_status_q;

endmodule

// ===== hw/rtl/rlol_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlol_ctrl
// Sequencer for clear, append and the cursor walk of a query.
// ----------------------------------------------------------------------------
module rlol_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  rlol_pkg::sts_t  sts_i,
  output rlol_pkg::cmd_t  cmd_o
);

  rlol_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlol_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlol_pkg::StIdle: if (in_valid_i) state_d = rlol_pkg::StExec;
      rlol_pkg::StExec: state_d = sts_i.is_query ? rlol_pkg::StSeek : rlol_pkg::StDone;
      rlol_pkg::StSeek: state_d = sts_i.walk_end ? rlol_pkg::StDone : rlol_pkg::StCmp;
      rlol_pkg::StCmp:  state_d = sts_i.covered ? rlol_pkg::StDone : rlol_pkg::StSeek;
      rlol_pkg::StDone: if (out_free) state_d = rlol_pkg::StIdle;
      default:          state_d = rlol_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      rlol_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rlol_pkg::StExec: cmd_o.exec  = 1'b1;
      rlol_pkg::StSeek: cmd_o.rd_en = !sts_i.walk_end;
      rlol_pkg::StCmp:  cmd_o.step  = 1'b1;
      rlol_pkg::StDone: begin
        cmd_o.out_load = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/run_length_offset_lookup.sv =====
// ----------------------------------------------------------------------------
// run_length_offset_lookup
// Table of runs (sample count, value) answering which value covers a sample
// index, walking forward from a kept cursor.
// ----------------------------------------------------------------------------
//   port    dir  payload
//   in_i    in   op, run_length, run_value, lookup_index
//   out_o   out  offset_value, hit, status
//
// clear, append and the unused op pass through the exec and done states; a query
// adds a seek and a compare state for each run examined and a final seek when the
// walk passes the last run (registered table read, then compare and step).
// rst_ni clears table fill level, cursor and handshake state at once.
// one item in work at a time; a result waits in the output register while the
// next item is taken, and a stalled output holds the sequencer before its load.
// ----------------------------------------------------------------------------
module run_length_offset_lookup (
  input  logic         clk_i,
  input  logic         rst_ni,
  rlol_in_if.sink      in_i,
  rlol_out_if.source   out_o
);

  rlol_pkg::cmd_t cmd;
  rlol_pkg::sts_t sts;

  rlol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rlol_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (in_i.op),
    .run_length_i   (in_i.run_length),
    .run_value_i    (in_i.run_value),
    .lookup_index_i (in_i.lookup_index),
    .offset_value_o (out_o.offset_value),
    .hit_o          (out_o.hit),
    .status_o       (out_o.status)
  );

  // no table read past the last valid run
  a_rd_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> !sts.walk_end)
    else $error("table read beyond fill level");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second transfer while item in work");

  // output load always presents a result next cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_o.valid)
    else $error("loaded result not presented");

  // walk steps only happen for queries
  a_step_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> sts.is_query)
    else $error("walk step outside a query");

endmodule

// ===== bench/rlol_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rlol_checker
// Watches both channels of the run-length offset lookup block. Every accepted
// request is resolved against a private copy of the run table and cursor.
// Every accepted response is compared field by field with the oldest pending
// lookup. Counts of errors, pending lookups and checked responses go to the
// bench top.
// ----------------------------------------------------------------------------
module rlol_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlol_in_if          req_i,
  rlol_out_if         rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  typedef struct packed {
    logic [rlol_pkg::DataW-1:0] offset_value;
    logic                       hit;
    logic                       status;
  } lookup_rsp_t;

  logic [rlol_pkg::DataW-1:0]  run_len_tbl [rlol_pkg::MaxRuns];
  logic [rlol_pkg::DataW-1:0]  run_val_tbl [rlol_pkg::MaxRuns];
  int unsigned                 runs_used;
  int unsigned                 walk_entry;
  logic [rlol_pkg::FirstW-1:0] walk_first;
  lookup_rsp_t                 lookups_due [$];

  function automatic lookup_rsp_t resolve_request(input logic [1:0] op,
                                                  input logic [rlol_pkg::DataW-1:0] len,
                                                  input logic [rlol_pkg::DataW-1:0] val,
                                                  input logic [rlol_pkg::DataW-1:0] idx);
    lookup_rsp_t                 rsp;
    logic                        found;
    logic [rlol_pkg::FirstW-1:0] wide_idx;
    rsp      = '0;
    found    = 1'b0;
    wide_idx = rlol_pkg::FirstW'(idx);
    case (op)
      rlol_pkg::OpClear: begin
        runs_used  = 0;
        walk_entry = 0;
        walk_first = '0;
      end
      rlol_pkg::OpAppend: begin
        if (runs_used < rlol_pkg::MaxRuns) begin
          run_len_tbl[runs_used] = len;
          run_val_tbl[runs_used] = val;
          runs_used++;
          walk_entry = 0;
          walk_first = '0;
        end else begin
          rsp.status = 1'b1;
        end
      end
      rlol_pkg::OpQuery: begin
        if (wide_idx < walk_first) begin
          walk_entry = 0;
          walk_first = '0;
        end
        // zero-length runs fall through since they never cover the index
        while (!found && walk_entry < runs_used) begin
          if (wide_idx < walk_first + rlol_pkg::FirstW'(run_len_tbl[walk_entry])) begin
            rsp.offset_value = run_val_tbl[walk_entry];
            rsp.hit          = 1'b1;
            found            = 1'b1;
          end else begin
            walk_first = walk_first + rlol_pkg::FirstW'(run_len_tbl[walk_entry]);
            walk_entry++;
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_rsp_t due;
    if (!rst_ni) begin
      lookups_due.delete();
      runs_used  = 0;
      walk_entry = 0;
      walk_first = '0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        lookups_due.push_back(resolve_request(req_i.op, req_i.run_length,
                                              req_i.run_value, req_i.lookup_index));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (lookups_due.size() == 0) begin
          errors_o++;
          $display("%0t: expected no response, got offset_value %h hit %b status %b",
                   $time, rsp_i.offset_value, rsp_i.hit, rsp_i.status);
        end else begin
          due = lookups_due.pop_front();
          checked_o++;
          if (rsp_i.offset_value !== due.offset_value) begin
            errors_o++;
            $display("%0t: offset_value expected %h got %h",
                     $time, due.offset_value, rsp_i.offset_value);
          end
          if (rsp_i.hit !== due.hit) begin
            errors_o++;
            $display("%0t: hit expected %b got %b", $time, due.hit, rsp_i.hit);
          end
          if (rsp_i.status !== due.status) begin
            errors_o++;
            $display("%0t: status expected %b got %b", $time, due.status, rsp_i.status);
          end
        end
      end
    end
    pending_o = lookups_due.size();
  end

endmodule

// ===== bench/run_length_offset_lookup_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_length_offset_lookup_test
// Bench top for the run-length offset lookup block. A short directed pass
// covers empty tables, zero-length and maximal runs, backward seeks, queries
// past the end and the unused op. Random episodes then build tables (now and
// then filled past capacity) and query them, often in the same run or the next,
// under phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module run_length_offset_lookup_test;

  localparam int unsigned RequestTarget = 1750;
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned DrainCycles   = 24;
  localparam logic [1:0]  OpIgnored     = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  rlol_in_if  req_if ();
  rlol_out_if rsp_if ();

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;

  int unsigned cycle_cnt;
  int unsigned requests_sent;
  int unsigned ignored_sent;
  int unsigned fills;
  int unsigned gap_pct;
  int unsigned stall_pct;

  // what the table holds, only to aim query indices
  logic [39:0] shadow_start [$];
  logic [31:0] shadow_len [$];
  logic [39:0] shadow_total;
  int unsigned query_run;

  run_length_offset_lookup u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  rlol_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("timeout after %0d cycles, %0d lookups still pending", cycle_cnt, pending);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [31:0] len,
                              input logic [31:0] val, input logic [31:0] idx);
    int unsigned phase;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.run_length   <= len;
    req_if.run_value    <= val;
    req_if.lookup_index <= idx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    case (op)
      rlol_pkg::OpClear: begin
        shadow_start.delete();
        shadow_len.delete();
        shadow_total = '0;
      end
      rlol_pkg::OpAppend: begin
        if (shadow_len.size() < rlol_pkg::MaxRuns) begin
          shadow_start.push_back(shadow_total);
          shadow_len.push_back(len);
          shadow_total = shadow_total + 40'(len);
        end
      end
      default: ;
    endcase
    if (op == OpIgnored) ignored_sent++;
    else requests_sent++;
    phase = requests_sent * 4 / RequestTarget;
    case (phase)
      0: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      1: begin
        gap_pct   = 56;
        stall_pct = 0;
      end
      2: begin
        gap_pct   = 0;
        stall_pct = 56;
      end
      default: begin
        gap_pct   = 21;
        stall_pct = 21;
      end
    endcase
  endtask

  function automatic logic [31:0] pick_length(input logic wide);
    int unsigned m;
    m = $urandom_range(99);
    if (m < 15) return '0;
    if (m < 65 || !wide) return 32'($urandom_range(1, 16));
    if (m < 80) return 32'($urandom_range(17, 1000));
    if (m < 90) return $urandom;
    return '1;
  endfunction

  function automatic logic [31:0] pick_index();
    int unsigned n;
    int unsigned mode;
    int unsigned k;
    logic [39:0] pos;
    logic [31:0] len;
    n    = shadow_len.size();
    mode = $urandom_range(99);
    if (n == 0 || mode >= 93) begin
      if (mode[0]) return $urandom;
      return mode[1] ? '1 : '0;
    end
    if (query_run >= n) query_run = n - 1;
    if (mode < 45) begin
      // typical case: same run or the next one
      k = query_run + $urandom_range(1);
      if (k >= n) k = n - 1;
    end else if (mode < 65 || (mode >= 75 && mode < 85)) begin
      k = $urandom_range(n - 1);
    end else if (mode < 75) begin
      k = $urandom_range(query_run);
    end else begin
      k = n - 1;
    end
    len = shadow_len[k];
    if (mode < 75) begin
      pos = shadow_start[k] + ((len <= 1) ? 40'd0 : 40'($urandom % len));
    end else if (mode < 85) begin
      pos = shadow_start[k] + 40'(len) - (mode[0] ? 40'd1 : 40'd0);
    end else begin
      pos = shadow_total + 40'($urandom_range(2));
    end
    query_run = k;
    return (pos > 40'hFFFF_FFFF) ? '1 : pos[31:0];
  endfunction

  initial begin
    int unsigned runs;
    int unsigned queries;
    int unsigned m;
    logic        fill;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.op           = rlol_pkg::OpClear;
    req_if.run_length   = '0;
    req_if.run_value    = '0;
    req_if.lookup_index = '0;
    shadow_total        = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty table, extremes, zero-length run, seeks, past the end
    send_request(rlol_pkg::OpQuery, '0, '0, '0);
    send_request(rlol_pkg::OpQuery, '1, '1, '1);
    send_request(OpIgnored, '1, '1, '1);
    send_request(rlol_pkg::OpAppend, '0, '1, '1);
    send_request(rlol_pkg::OpAppend, 32'd1, '0, '1);
    send_request(rlol_pkg::OpAppend, '1, 32'hA5A5_A5A5, '0);
    send_request(rlol_pkg::OpQuery, '1, '1, '0);
    send_request(rlol_pkg::OpQuery, '0, '0, 32'd1);
    send_request(rlol_pkg::OpQuery, '0, '0, '1);
    send_request(rlol_pkg::OpQuery, '0, '0, '0);
    send_request(rlol_pkg::OpClear, '1, '1, '1);
    send_request(rlol_pkg::OpQuery, '0, '0, 32'd5);
    send_request(rlol_pkg::OpAppend, 32'd3, 32'd7, '0);
    send_request(rlol_pkg::OpAppend, '0, 32'd9, '0);
    send_request(rlol_pkg::OpAppend, 32'd2, 32'd11, '0);
    send_request(rlol_pkg::OpQuery, '0, '0, 32'd4);
    send_request(rlol_pkg::OpQuery, '0, '0, 32'd5);
    send_request(rlol_pkg::OpQuery, '0, '0, 32'd2);
    send_request(rlol_pkg::OpQuery, '0, '0, 32'd3);
    send_request(rlol_pkg::OpAppend, '1, '0, '1);
    send_request(rlol_pkg::OpQuery, '0, '0, '1);
    send_request(rlol_pkg::OpQuery, '1, '1, 32'd6);
    send_request(OpIgnored, '0, '0, '0);
    send_request(rlol_pkg::OpClear, '0, '0, '0);

    while (requests_sent < RequestTarget) begin
      fill = (fills < 2) && ($urandom_range(99) < 2 ||
                             (fills == 0 && requests_sent > RequestTarget / 3));
      if (fill || $urandom_range(99) < 80) begin
        send_request(rlol_pkg::OpClear, $urandom, $urandom, $urandom);
      end
      m = $urandom_range(99);
      if (fill) begin
        // past capacity, so the last appends are dropped
        runs = rlol_pkg::MaxRuns + $urandom_range(1, 3);
        fills++;
      end else if (m < 5) begin
        runs = 0;
      end else if (m < 80) begin
        runs = $urandom_range(1, 10);
      end else begin
        runs = $urandom_range(11, 40);
      end
      for (int unsigned i = 0; i < runs; i++) begin
        if ($urandom_range(99) < 4) send_request(OpIgnored, $urandom, $urandom, $urandom);
        send_request(rlol_pkg::OpAppend, pick_length(!fill), $urandom, $urandom);
      end
      queries   = fill ? $urandom_range(6, 12) : $urandom_range(2, 14);
      query_run = 0;
      for (int unsigned i = 0; i < queries; i++) begin
        m = $urandom_range(99);
        if (m < 4) begin
          send_request(OpIgnored, $urandom, $urandom, $urandom);
        end else if (m < 8) begin
          send_request(rlol_pkg::OpAppend, pick_length(1'b1), $urandom, $urandom);
        end
        send_request(rlol_pkg::OpQuery, $urandom, $urandom, pick_index());
      end
    end
    req_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("sent %0d requests plus %0d unused-op items, %0d responses checked",
             requests_sent, ignored_sent, checked);
    $display("%0d full-table fills, %0d cycles, %0d errors", fills, cycle_cnt, errors);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
